FILE: hdl/additive_partial_oscillator_top_macros.svh
// ----------------------------------------------------------------------------
// additive partial oscillator assertion macros
// shared assertion forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_PARTIAL_OSCILLATOR_TOP_MACROS_SVH
`define ADDITIVE_PARTIAL_OSCILLATOR_TOP_MACROS_SVH

// same-cycle implication
`define APO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/apo_pkg.sv
// ----------------------------------------------------------------------------
// apo_pkg
// shared types and constants of the additive partial oscillator
// ----------------------------------------------------------------------------
package apo_pkg;

  // field widths
  localparam int AMP_W   = 20;
  localparam int PHASE_W = 32;
  localparam int T_W     = 31;

  // sine quantization: table depth is a power of two
  localparam int SINE_LOG2 = 10;
  localparam logic [PHASE_W-1:0] SINE_MASK = ~((32'd1 << (PHASE_W - SINE_LOG2)) - 32'd1);

  // polynomial coefficients, Q30
  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;
  localparam logic [T_W-1:0] Q30_ONE = 31'd1073741824;

  // register reset values
  localparam logic [PHASE_W-1:0] NYQ_RESET    = 32'd2104533975;
  localparam logic [AMP_W-1:0]   MINAMP_RESET = 20'd6;

  // command codes
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2
  } apo_cmd_t;

  // register indexes
  localparam logic CFG_NYQUIST = 1'b0;
  localparam logic CFG_MIN_AMP = 1'b1;

  // per-partial control riding along the sine pipeline
  typedef struct packed {
    logic             vld;
    logic             last;
    logic             act;
    logic             neg;
    logic [AMP_W-1:0] amp;
  } apo_tag_t;

endpackage

FILE: hdl/apo_sine.sv
// ----------------------------------------------------------------------------
// apo_sine
// pipelined odd-polynomial sine magnitude times amplitude, one partial a cycle
// ----------------------------------------------------------------------------
`include "additive_partial_oscillator_top_macros.svh"

module apo_sine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [apo_pkg::T_W-1:0]       t_i,
  input  apo_pkg::apo_tag_t             tag_i,
  output logic [apo_pkg::AMP_W-1:0]     mag_o,
  output apo_pkg::apo_tag_t             tag_o
);

  localparam int LAT = 8;
  localparam int TW  = apo_pkg::T_W;
  localparam int AW  = apo_pkg::AMP_W;

  apo_pkg::apo_tag_t tag_r [LAT];
  logic [TW-1:0]     t_r   [6];
  logic [TW-1:0]     t2_r  [4];
  logic [31:0]       s_r   [4];
  logic [TW-1:0]     r_r;
  logic [AW-1:0]     mag_r;

  logic [61:0]       p_tt;
  logic [62:0]       p_s9;
  logic [62:0]       p_s5;
  logic [62:0]       p_s3;
  logic [62:0]       p_s1;
  logic [62:0]       p_r;
  logic [32:0]       r_full;
  logic [50:0]       p_mag;

  // products of each stage
  always_comb begin
    p_tt   = 62'(t_r[0]) * 62'(t_r[0]);
    p_s9   = 63'(t2_r[0]) * 63'(apo_pkg::C9);
    p_s5   = 63'(t2_r[1]) * 63'(s_r[0]);
    p_s3   = 63'(t2_r[2]) * 63'(s_r[1]);
    p_s1   = 63'(t2_r[3]) * 63'(s_r[2]);
    p_r    = 63'(t_r[5]) * 63'(s_r[3]);
    r_full = p_r[62:30];
    p_mag  = 51'(r_r) * 51'(tag_r[6].amp) + 51'(1) * (51'(1) << 29);
  end

  // control tags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) tag_r[i] <= '0;
    end else begin
      tag_r[0] <= tag_i;
      for (int i = 1; i < LAT; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    t_r[0] <= t_i;
    for (int i = 1; i < 6; i++) t_r[i] <= t_r[i-1];
    t2_r[0] <= p_tt[60:30];
    for (int i = 1; i < 4; i++) t2_r[i] <= t2_r[i-1];
    s_r[0] <= apo_pkg::C7 - p_s9[61:30];
    s_r[1] <= apo_pkg::C5 - p_s5[61:30];
    s_r[2] <= apo_pkg::C3 - p_s3[61:30];
    s_r[3] <= apo_pkg::C1 - p_s1[61:30];
    r_r    <= (r_full > 33'(apo_pkg::Q30_ONE)) ? apo_pkg::Q30_ONE : r_full[TW-1:0];
    mag_r  <= p_mag[49:30];
  end

  assign mag_o = mag_r;
  assign tag_o = tag_r[LAT-1];

  // every partial entering comes out after the fixed latency
  `APO_ASSERT_IMP(a_sine_latency, tag_i.vld, ##LAT tag_o.vld, "sine pipeline lost a partial")

endmodule

FILE: hdl/additive_partial_oscillator_top.sv
// ----------------------------------------------------------------------------
// additive_partial_oscillator_top
// bank of harmonic partials summed into one sample per tick item
// ----------------------------------------------------------------------------
//  channel  ports                                          dir  handshake
//  in       in_cmd in_fundamental_step in_partial_index    in   in_valid / in_stall
//           in_amplitude_value
//  out      out_sample_out                                 out  out_valid / out_stall
//  cfg      cfg_we cfg_index cfg_wdata                     in   write on cfg_we
//
//  a tick is taken only in idle; in_stall stays high until its sample is
//  handed to the output register; partials leave the phase and amplitude
//  memories one per cycle and run through the 8-stage sine pipeline
//  load and clear items are applied as they are taken, without leaving idle
//  reset clears the phase and amplitude valid bits at once, no clearing pass
//  a finished sample waits in the output register while out_stall is high
// ----------------------------------------------------------------------------
`include "additive_partial_oscillator_top_macros.svh"

module additive_partial_oscillator_top #(
  parameter int NUM_PARTIALS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [31:0]        in_fundamental_step,
  input  logic [5:0]         in_partial_index,
  input  logic [19:0]        in_amplitude_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sample_out,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int IDX_W = (NUM_PARTIALS > 1) ? $clog2(NUM_PARTIALS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTIALS + 1);
  localparam int INC_W = 32 + CNT_W;
  localparam int AW    = apo_pkg::AMP_W;
  localparam int PW    = apo_pkg::PHASE_W;
  localparam int TW    = apo_pkg::T_W;
  localparam int SUM_W = AW + CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTIALS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // configuration registers
  logic [PW-1:0] nyq_r;
  logic [AW-1:0] min_r;

  // memories and their valid bits
  logic [PW-1:0]           phase_mem [NUM_PARTIALS];
  logic [AW-1:0]           amp_mem   [NUM_PARTIALS];
  logic [NUM_PARTIALS-1:0] phase_vld_r;
  logic [NUM_PARTIALS-1:0] amp_vld_r;

  // control
  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [INC_W-1:0]        inc_r, inc_nxt;
  logic [PW-1:0]           step_r, step_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    fin_r, fin_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [31:0]      out_sample_r, out_sample_nxt;

  logic             in_acc;
  logic             issue;
  logic             out_free;
  logic             load_en;
  logic [IDX_W+5:0] pidx_ext;
  logic [IDX_W-1:0] load_idx;

  // read stage
  logic             s1_vld_r;
  logic             s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [INC_W-1:0] s1_inc_r;
  logic [PW-1:0]    phase_rd_r;
  logic [AW-1:0]    amp_rd_r;
  logic             ph_ok_r;
  logic             am_ok_r;

  logic [PW-1:0]     s1_phase;
  logic [AW-1:0]     s1_amp;
  logic              s1_act;
  logic              wb_en;
  logic [PW-1:0]     wb_data;
  logic [PW-1:0]     ph_q;
  logic [TW-1:0]     t_lin;
  logic [TW-1:0]     sine_t;
  apo_pkg::apo_tag_t sine_tag_in;
  apo_pkg::apo_tag_t sine_tag;
  logic [AW-1:0]     sine_mag;
  logic signed [SUM_W-1:0] term;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign issue     = (state_r == ST_ISSUE);
  assign out_free  = !out_valid_r || !out_stall;
  assign pidx_ext  = {{IDX_W{1'b0}}, in_partial_index};
  assign load_idx  = pidx_ext[IDX_W-1:0];
  assign load_en   = in_acc && (in_cmd == apo_pkg::CMD_LOAD)
                     && (pidx_ext < (IDX_W+6)'(NUM_PARTIALS));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nyq_r <= apo_pkg::NYQ_RESET;
      min_r <= apo_pkg::MINAMP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        apo_pkg::CFG_NYQUIST: nyq_r <= cfg_wdata;
        apo_pkg::CFG_MIN_AMP: min_r <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // amplitude memory, written by load items
  always_ff @(posedge clk) begin
    if (load_en) amp_mem[load_idx] <= in_amplitude_value;
  end

  // phase memory, written back by the read stage
  always_ff @(posedge clk) begin
    if (wb_en) phase_mem[s1_idx_r] <= wb_data;
  end

  // memory reads, one partial per cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      phase_rd_r <= phase_mem[k_r];
      amp_rd_r   <= amp_mem[k_r];
      ph_ok_r    <= phase_vld_r[k_r];
      am_ok_r    <= amp_vld_r[k_r];
      s1_idx_r   <= k_r;
      s1_inc_r   <= inc_r;
      s1_last_r  <= (k_r == LAST_IDX);
    end
  end

  // valid bits: entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_vld_r <= '0;
      amp_vld_r   <= '0;
      s1_vld_r    <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      if (in_acc && (in_cmd == apo_pkg::CMD_CLEAR)) phase_vld_r <= '0;
      else if (wb_en) phase_vld_r[s1_idx_r] <= 1'b1;
      if (load_en) amp_vld_r[load_idx] <= 1'b1;
    end
  end

  // skip test, phase advance and sine argument
  always_comb begin
    s1_phase = ph_ok_r ? phase_rd_r : '0;
    s1_amp   = am_ok_r ? amp_rd_r : '0;
    s1_act   = s1_vld_r && (s1_inc_r < INC_W'(nyq_r)) && (s1_amp > min_r);
    wb_en    = s1_act;
    wb_data  = s1_phase + s1_inc_r[PW-1:0];
    ph_q     = s1_phase & apo_pkg::SINE_MASK;
    t_lin    = {1'b0, ph_q[29:0]};
    sine_t   = ph_q[30] ? (apo_pkg::Q30_ONE - t_lin) : t_lin;
    sine_tag_in.vld  = s1_vld_r;
    sine_tag_in.last = s1_last_r;
    sine_tag_in.act  = s1_act;
    sine_tag_in.neg  = ph_q[31];
    sine_tag_in.amp  = s1_amp;
  end

  apo_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .t_i   (sine_t),
    .tag_i (sine_tag_in),
    .mag_o (sine_mag),
    .tag_o (sine_tag)
  );

  // signed term of one partial
  always_comb begin
    term = signed'(SUM_W'(sine_mag));
    if (sine_tag.neg) term = -term;
    if (!sine_tag.act) term = '0;
  end

  // sequencer, accumulator and output register
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    inc_nxt        = inc_r;
    step_nxt       = step_r;
    sum_nxt        = sum_r;
    fin_nxt        = fin_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == apo_pkg::CMD_TICK)) begin
          state_nxt = ST_ISSUE;
          k_nxt     = '0;
          inc_nxt   = INC_W'(in_fundamental_step);
          step_nxt  = in_fundamental_step;
          sum_nxt   = '0;
        end
      end
      ST_ISSUE: begin
        k_nxt   = k_r + IDX_W'(1);
        inc_nxt = inc_r + INC_W'(step_r);
        if (k_r == LAST_IDX) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // sum width fits in 32 bits for up to 2047 partials, so no clamp
        if (fin_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = 32'(sum_r);
          fin_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (sine_tag.vld) begin
      sum_nxt = sum_r + term;
      if (sine_tag.last) fin_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      fin_r        <= fin_nxt;
      out_valid_r  <= out_valid_nxt;
      inc_r        <= inc_nxt;
      step_r       <= step_nxt;
      sum_r        <= sum_nxt;
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  `APO_ASSERT_IMP(a_wb_busy, wb_en, state_r != ST_IDLE, "phase written back while idle")
  `APO_ASSERT_IMP(a_last_drain, sine_tag.vld && sine_tag.last,
                  state_r == ST_DRAIN && !fin_r, "last partial outside drain")
  `APO_ASSERT_NXT(a_fin_out, fin_r && state_r == ST_DRAIN && out_free,
                  out_valid_r && !fin_r && state_r == ST_IDLE,
                  "finished sample not handed out")
  `APO_ASSERT_IMP(a_issue_range, state_r == ST_ISSUE, k_r <= LAST_IDX, "issue index past last partial")

endmodule
